@@ hw/rtl/iba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types, widths and codes for the indexed block allocator.
// ----------------------------------------------------------------------------
package iba_pkg;

  localparam int DISK_BLOCKS  = 32;
  localparam int BLK_W        = $clog2(DISK_BLOCKS);
  localparam int CNT_W        = $clog2(DISK_BLOCKS + 1);
  localparam int RESULT_LIMIT = 32;

  localparam int BB_W         = 16;
  localparam int BYTES_W      = 20;
  localparam int IDX_W        = 5;
  localparam int FILE_W       = 16;
  localparam int BLKNUM_W     = 5;
  localparam int PART_W       = 6;
  localparam int STATUS_W     = 2;

  // numerator is bytes + divisor - 1, one bit wider than the byte count
  localparam int NUM_W        = BYTES_W + 1;
  localparam int STEP_W       = $clog2(NUM_W);

  localparam logic [BB_W-1:0] BLOCK_BYTES_RESET = BB_W'(512);

  localparam logic ACT_FREE  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOC = 2'd0,
    STAT_FAIL  = 2'd1,
    STAT_FREED = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/iba_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iba_div
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// ----------------------------------------------------------------------------
module iba_div
  import iba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [BB_W-1:0]  den,
  output div_res_t              res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BB_W-1:0]   den_r, den_nxt;
  logic [BB_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;

  logic [BB_W:0]     trial;
  logic [BB_W+1:0]   diff;
  logic              ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diff[BB_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[BB_W-1:0] : trial[BB_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule
`default_nettype wire

@@ hw/rtl/indexed_block_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_block_allocator_top
// First-fit block allocator over a free bitmap with per-block result stream.
// ----------------------------------------------------------------------------
// A mark-free transaction or a zero-size allocation is answered with one
// result straight from idle. A sized allocation first runs the serial ceiling
// division in the divider, one quotient bit at a time, then checks the block
// count against the free count and the result limit, then scans the free
// bitmap one block per cycle while the output is not stalled, up to the
// highest block it claims. The input is not ready while an allocation is in
// progress. block_bytes should only be written while idle; a value of zero
// divides as one.
module indexed_block_allocator_top
  import iba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input: tdata = block_index[4:0], file_bytes[24:5], zero fill
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tuser,   // action
  // result: tdata = status[1:0], file_number[17:2], block_number[22:18],
  //         partition_number[28:23], zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  // block size register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  state_t                 state_r, state_nxt;
  logic [BB_W-1:0]        bb_r, bb_nxt;
  logic [DISK_BLOCKS-1:0] map_r, map_nxt;
  logic [CNT_W-1:0]       free_cnt_r, free_cnt_nxt;
  logic [FILE_W-1:0]      file_r, file_nxt;
  logic [PART_W-1:0]      parts_r, parts_nxt;
  logic [PART_W-1:0]      k_r, k_nxt;
  logic [BLK_W-1:0]       j_r, j_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [FILE_W-1:0]      out_file_r, out_file_nxt;
  logic [BLKNUM_W-1:0]    out_block_r, out_block_nxt;
  logic [PART_W-1:0]      out_part_r, out_part_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [IDX_W-1:0]       in_idx;
  logic [BYTES_W-1:0]     in_bytes;
  logic                   in_fire;
  logic                   slot_free;
  logic [BB_W-1:0]        den;
  logic [NUM_W-1:0]       num;
  logic [DISK_BLOCKS-1:0] idx_mask;
  logic                   div_start;
  div_res_t               div_res;
  logic                   fail;
  logic [PART_W-1:0]      k_inc;

  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_bytes  = in_tdata[IDX_W+BYTES_W-1:IDX_W];
  assign slot_free = ~out_valid_r | out_tready;
  assign in_tready = (state_r == ST_IDLE) & slot_free;
  assign in_fire   = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  assign den      = (bb_r == '0) ? BB_W'(1) : bb_r;
  assign num      = NUM_W'(in_bytes) + NUM_W'(den) - NUM_W'(1);
  assign idx_mask = DISK_BLOCKS'(1) << in_idx;
  assign fail     = (div_res.quotient > NUM_W'(RESULT_LIMIT)) ||
                    (div_res.quotient > NUM_W'(free_cnt_r));
  assign k_inc    = k_r + PART_W'(1);

  iba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .res   (div_res)
  );

  always_comb begin
    state_nxt      = state_r;
    bb_nxt         = bb_r;
    map_nxt        = map_r;
    free_cnt_nxt   = free_cnt_r;
    file_nxt       = file_r;
    parts_nxt      = parts_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_file_nxt   = out_file_r;
    out_block_nxt  = out_block_r;
    out_part_nxt   = out_part_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;

    if (cfg_valid) begin
      bb_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == ACT_FREE) begin
            if (32'(in_idx) < DISK_BLOCKS) begin
              map_nxt = map_r | idx_mask;
              if ((map_r & idx_mask) == '0) begin
                free_cnt_nxt = free_cnt_r + CNT_W'(1);
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_FREED;
              out_file_nxt   = '0;
              out_block_nxt  = BLKNUM_W'(in_idx);
              out_part_nxt   = '0;
              out_last_nxt   = 1'b1;
            end
          end else if (in_bytes == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_EMPTY;
            out_file_nxt   = file_r;
            out_block_nxt  = '0;
            out_part_nxt   = '0;
            out_last_nxt   = 1'b1;
            file_nxt       = file_r + FILE_W'(1);
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fail) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FAIL;
            out_file_nxt   = file_r;
            out_block_nxt  = '0;
            out_part_nxt   = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          parts_nxt = div_res.quotient[PART_W-1:0];
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (map_r[j_r]) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_ALLOC;
            out_file_nxt   = file_r;
            out_block_nxt  = BLKNUM_W'(j_r);
            out_part_nxt   = k_inc;
            out_last_nxt   = (k_inc == parts_r);
            map_nxt        = map_r & ~(DISK_BLOCKS'(1) << j_r);
            k_nxt          = k_inc;
            j_nxt          = j_r + BLK_W'(1);
            if (k_inc == parts_r) begin
              file_nxt     = file_r + FILE_W'(1);
              free_cnt_nxt = free_cnt_r - CNT_W'(parts_r);
              state_nxt    = ST_IDLE;
            end
          end
        end else begin
          j_nxt = j_r + BLK_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bb_r        <= BLOCK_BYTES_RESET;
      map_r       <= '0;
      free_cnt_r  <= '0;
      file_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bb_r        <= bb_nxt;
      map_r       <= map_nxt;
      free_cnt_r  <= free_cnt_nxt;
      file_r      <= file_nxt;
      out_valid_r <= out_valid_nxt;
    end
    parts_r      <= parts_nxt;
    k_r          <= k_nxt;
    j_r          <= j_nxt;
    out_status_r <= out_status_nxt;
    out_file_r   <= out_file_nxt;
    out_block_r  <= out_block_nxt;
    out_part_r   <= out_part_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_part_r, out_block_r, out_file_r, out_status_r};

endmodule
`default_nettype wire

@@ hw/rtl/iba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iba_checker
// Port-level checks for the indexed block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module iba_checker
  import iba_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [15:0] cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // single results carry no partition and close the item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != STAT_ALLOC) |->
      (out_tdata[28:23] == '0) && out_tlast)
    else $error("non-allocation result without last or with partition");

  // claimed blocks carry partition numbers from one
  a_part_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == STAT_ALLOC) |-> (out_tdata[28:23] != '0))
    else $error("allocation result with partition zero");

  // a sized allocation holds off the input while it divides
  a_busy_after_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_ALLOC) && (in_tdata[24:5] != '0)
      |=> !in_tready)
    else $error("input ready during allocation");

endmodule

bind indexed_block_allocator_top iba_checker u_iba_checker (.*);
`default_nettype wire
